// ===== rtl/core/fbfa_pkg.sv =====
// shared types, constants and state codes for the segment allocator
// no dependencies
`timescale 1ns / 1ps

package fbfa_pkg;

  localparam int SIZE_W           = 21;
  localparam int ID_W             = 16;
  localparam int ADDR_W           = 20;
  localparam int CFG_IDX_W        = 2;
  localparam int MAX_SEGMENTS_DEF = 64;

  localparam logic [SIZE_W-1:0] SPACE_MAX = 21'd1048576;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SPACE = 2'd1;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic POLICY_FIRST = 1'b0;
  localparam logic POLICY_BEST  = 1'b1;

  typedef struct packed {
    logic              used;
    logic [ID_W-1:0]   owner;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic              granted;
    logic [ADDR_W-1:0] alloc_address;
    logic [SIZE_W-1:0] total_free;
    logic [SIZE_W-1:0] largest_free;
  } result_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_PLACE0,
    S_PLACE1,
    S_FNEXT,
    S_FMERGE,
    S_COMPACT,
    S_STATS,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/fbfa_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module fbfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/fbfa_engine.sv =====
// sequencer that walks the segment table: search, insert shift, merge,
// compaction and free-space totals; depends on fbfa_pkg and fbfa_ram ports
`timescale 1ns / 1ps

module fbfa_engine #(
  parameter int MAX_SEGMENTS = fbfa_pkg::MAX_SEGMENTS_DEF,
  parameter int IW           = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       reinit,
  input  logic                       fit_policy,
  input  logic [fbfa_pkg::SIZE_W-1:0] total_space,
  input  logic                       in_fire,
  input  logic                       func,
  input  logic [fbfa_pkg::ID_W-1:0]  request_id,
  input  logic [fbfa_pkg::SIZE_W-1:0] req_size,
  output logic                       idle,
  output logic                       res_valid,
  input  logic                       res_ready,
  output fbfa_pkg::result_t          res,
  output logic                       ram_we,
  output logic [IW-1:0]              ram_waddr,
  output fbfa_pkg::entry_t           ram_wdata,
  output logic [IW-1:0]              ram_raddr,
  input  fbfa_pkg::entry_t           ram_rdata
);

  import fbfa_pkg::*;

  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);
  localparam logic [CW-1:0] ONE     = CW'(1);

  state_t state, state_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [CW-1:0]     idx, idx_next;
  logic              vld, vld_next;
  logic [CW-1:0]     vidx, vidx_next;
  logic              stop, stop_next;
  logic              func_r, func_r_next;
  logic [ID_W-1:0]   id_r, id_r_next;
  logic [SIZE_W-1:0] sz_r, sz_r_next;
  logic              found, found_next;
  logic [CW-1:0]     pick, pick_next;
  logic [SIZE_W-1:0] pick_addr, pick_addr_next;
  logic [SIZE_W-1:0] pick_size, pick_size_next;
  logic [SIZE_W-1:0] acc, acc_next;
  logic              prev_free, prev_free_next;
  logic [SIZE_W-1:0] prev_size, prev_size_next;
  logic              nxt_free, nxt_free_next;
  logic [SIZE_W-1:0] nxt_size, nxt_size_next;
  logic              ok, ok_next;
  logic [SIZE_W-1:0] tot, tot_next;
  logic [SIZE_W-1:0] big, big_next;
  logic [1:0]        rem, rem_next;

  logic              issue;
  logic              fits;
  logic [SIZE_W-1:0] merged;
  logic [1:0]        mrg_r;
  logic [CW-1:0]     mrg_p;

  // read issue per walking state
  always_comb begin
    case (state)
      S_SCAN:    issue = !stop && (idx < cnt);
      S_SHIFT:   issue = !stop;
      S_COMPACT: issue = idx < cnt;
      S_STATS:   issue = idx < cnt;
      default:   issue = 1'b0;
    endcase
  end

  assign fits   = !ram_rdata.used && (ram_rdata.size >= sz_r) && (sz_r != '0);
  assign merged = pick_size + (nxt_free ? nxt_size : '0);
  assign mrg_r  = prev_free ? (2'd1 + {1'b0, nxt_free}) : {1'b0, nxt_free};
  assign mrg_p  = prev_free ? pick : pick + ONE;

  // next state and register updates
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    idx_next       = issue ? idx + ONE : idx;
    vld_next       = issue;
    vidx_next      = idx;
    stop_next      = stop;
    func_r_next    = func_r;
    id_r_next      = id_r;
    sz_r_next      = sz_r;
    found_next     = found;
    pick_next      = pick;
    pick_addr_next = pick_addr;
    pick_size_next = pick_size;
    acc_next       = acc;
    prev_free_next = prev_free;
    prev_size_next = prev_size;
    nxt_free_next  = nxt_free;
    nxt_size_next  = nxt_size;
    ok_next        = ok;
    tot_next       = tot;
    big_next       = big;
    rem_next       = rem;
    case (state)
      S_INIT: begin
        cnt_next   = ONE;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (reinit) begin
          state_next = S_INIT;
        end else if (in_fire) begin
          func_r_next    = func;
          id_r_next      = request_id;
          sz_r_next      = req_size;
          idx_next       = '0;
          stop_next      = 1'b0;
          found_next     = 1'b0;
          acc_next       = '0;
          prev_free_next = 1'b0;
          prev_size_next = '0;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (vld) begin
          if (func_r == FUNC_ALLOC) begin
            if (fits && (!found ||
                (fit_policy == POLICY_BEST && ram_rdata.size < pick_size))) begin
              found_next     = 1'b1;
              pick_next      = vidx;
              pick_addr_next = acc;
              pick_size_next = ram_rdata.size;
              if (fit_policy == POLICY_FIRST) begin
                stop_next = 1'b1;
              end
            end
            acc_next = acc + ram_rdata.size;
          end else if (!found) begin
            if (ram_rdata.used && ram_rdata.owner == id_r) begin
              found_next     = 1'b1;
              pick_next      = vidx;
              pick_size_next = ram_rdata.size;
              stop_next      = 1'b1;
            end else begin
              prev_free_next = !ram_rdata.used;
              prev_size_next = ram_rdata.size;
            end
          end
        end
        if (!issue && !vld) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        idx_next  = '0;
        tot_next  = '0;
        big_next  = '0;
        stop_next = 1'b0;
        if (func_r == FUNC_ALLOC) begin
          if (!found) begin
            ok_next    = 1'b0;
            state_next = S_STATS;
          end else if (pick_size == sz_r) begin
            ok_next    = 1'b1;
            state_next = S_STATS;
          end else if (cnt == CNT_MAX) begin
            ok_next    = 1'b0;
            state_next = S_STATS;
          end else begin
            ok_next = 1'b1;
            if (cnt > pick + ONE) begin
              idx_next   = cnt - ONE;
              state_next = S_SHIFT;
            end else begin
              state_next = S_PLACE0;
            end
          end
        end else begin
          if (!found) begin
            ok_next    = 1'b0;
            state_next = S_STATS;
          end else begin
            ok_next = 1'b1;
            if (pick + ONE < cnt) begin
              state_next = S_FNEXT;
            end else begin
              nxt_free_next = 1'b0;
              nxt_size_next = '0;
              state_next    = S_FMERGE;
            end
          end
        end
      end
      S_SHIFT: begin
        // copy entries one place up, highest first
        if (issue) begin
          idx_next  = idx - ONE;
          stop_next = (idx == pick + ONE);
        end
        if (!issue && !vld) begin
          state_next = S_PLACE0;
        end
      end
      S_PLACE0: begin
        state_next = S_PLACE1;
      end
      S_PLACE1: begin
        cnt_next   = cnt + ONE;
        idx_next   = '0;
        tot_next   = '0;
        big_next   = '0;
        state_next = S_STATS;
      end
      S_FNEXT: begin
        nxt_free_next = !ram_rdata.used;
        nxt_size_next = ram_rdata.size;
        state_next    = S_FMERGE;
      end
      S_FMERGE: begin
        rem_next = mrg_r;
        if (mrg_r == 2'd0) begin
          idx_next   = '0;
          tot_next   = '0;
          big_next   = '0;
          state_next = S_STATS;
        end else begin
          idx_next   = mrg_p + CW'(mrg_r);
          state_next = S_COMPACT;
        end
      end
      S_COMPACT: begin
        // pull later entries down over the merged ones
        if (!issue && !vld) begin
          cnt_next   = cnt - CW'(rem);
          idx_next   = '0;
          tot_next   = '0;
          big_next   = '0;
          state_next = S_STATS;
        end
      end
      S_STATS: begin
        if (vld && !ram_rdata.used) begin
          tot_next = tot + ram_rdata.size;
          if (ram_rdata.size > big) begin
            big_next = ram_rdata.size;
          end
        end
        if (!issue && !vld) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  // memory port drive
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = idx[IW-1:0];
    case (state)
      S_INIT: begin
        ram_we         = 1'b1;
        ram_wdata.size = total_space;
      end
      S_DECIDE: begin
        ram_raddr = IW'(pick + ONE);
        if (func_r == FUNC_ALLOC && found && pick_size == sz_r) begin
          ram_we    = 1'b1;
          ram_waddr = pick[IW-1:0];
          ram_wdata = '{used: 1'b1, owner: id_r, size: sz_r};
        end
      end
      S_SHIFT: begin
        ram_we    = vld;
        ram_waddr = IW'(vidx + ONE);
        ram_wdata = ram_rdata;
      end
      S_PLACE0: begin
        ram_we    = 1'b1;
        ram_waddr = pick[IW-1:0];
        ram_wdata = '{used: 1'b1, owner: id_r, size: sz_r};
      end
      S_PLACE1: begin
        ram_we         = 1'b1;
        ram_waddr      = IW'(pick + ONE);
        ram_wdata.size = pick_size - sz_r;
      end
      S_FMERGE: begin
        ram_we = 1'b1;
        if (prev_free) begin
          ram_waddr      = IW'(pick - ONE);
          ram_wdata.size = prev_size + merged;
        end else begin
          ram_waddr      = pick[IW-1:0];
          ram_wdata.size = merged;
        end
      end
      S_COMPACT: begin
        ram_we    = vld;
        ram_waddr = IW'(vidx - CW'(rem));
        ram_wdata = ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign idle                = (state == S_IDLE);
  assign res_valid           = (state == S_DONE);
  assign res.granted         = ok;
  assign res.alloc_address   = (ok && func_r == FUNC_ALLOC) ? pick_addr[ADDR_W-1:0] : '0;
  assign res.total_free      = tot;
  assign res.largest_free    = big;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= ONE;
      vld   <= 1'b0;
      stop  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      vld   <= vld_next;
      stop  <= stop_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    vidx      <= vidx_next;
    func_r    <= func_r_next;
    id_r      <= id_r_next;
    sz_r      <= sz_r_next;
    found     <= found_next;
    pick      <= pick_next;
    pick_addr <= pick_addr_next;
    pick_size <= pick_size_next;
    acc       <= acc_next;
    prev_free <= prev_free_next;
    prev_size <= prev_size_next;
    nxt_free  <= nxt_free_next;
    nxt_size  <= nxt_size_next;
    ok        <= ok_next;
    tot       <= tot_next;
    big       <= big_next;
    rem       <= rem_next;
  end

endmodule

// ===== rtl/core/first_best_fit_allocator.sv =====
// top level of the segment allocator: config registers, output register,
// table memory and sequencer; depends on fbfa_pkg, fbfa_ram, fbfa_engine
`timescale 1ns / 1ps

// Segment allocator with first-fit or best-fit placement and coalescing on
// free. The managed space is kept as an ordered table of contiguous segments
// in one block ram (one entry per segment: used flag, owner id, size). Each
// word walks the table through the single read port: a search pass over the
// live segments, then for a split an upward shift of the entries above the
// pick, or for a free a compaction pass after the merge, and finally a pass
// that sums free space and finds the largest free segment. Words are
// processed one at a time; the next word is taken while the previous result
// still sits in the output register. After reset, and after a write of
// total_space that reaches the sequencer while it is idle, the table is
// rebuilt as one free segment; no word is taken while the rebuild is pending.

module first_best_fit_allocator #(
  parameter int MAX_SEGMENTS = fbfa_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // input words
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        func,
  input  logic [fbfa_pkg::ID_W-1:0]   request_id,
  input  logic [fbfa_pkg::SIZE_W-1:0] req_size,
  // result words
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        granted,
  output logic [fbfa_pkg::ADDR_W-1:0] alloc_address,
  output logic [fbfa_pkg::SIZE_W-1:0] total_free,
  output logic [fbfa_pkg::SIZE_W-1:0] largest_free,
  // config writes
  input  logic                           cfg_we,
  input  logic [fbfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbfa_pkg::SIZE_W-1:0]    cfg_data
);

  import fbfa_pkg::*;

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  logic              fit_policy;
  logic [SIZE_W-1:0] total_space, total_space_next;
  logic              reinit;

  logic    eng_idle;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  logic    in_fire;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [IW-1:0] ram_raddr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;

  // clamp space to 1 .. SPACE_MAX
  always_comb begin
    if (cfg_data == '0) begin
      total_space_next = SIZE_W'(1);
    end else if (cfg_data > SPACE_MAX) begin
      total_space_next = SPACE_MAX;
    end else begin
      total_space_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy  <= POLICY_FIRST;
      total_space <= SPACE_MAX;
      reinit      <= 1'b0;
    end else begin
      reinit <= cfg_we && (cfg_index == CFG_TOTAL_SPACE);
      if (cfg_we && cfg_index == CFG_FIT_POLICY) begin
        fit_policy <= cfg_data[0];
      end
      if (cfg_we && cfg_index == CFG_TOTAL_SPACE) begin
        total_space <= total_space_next;
      end
    end
  end

  // hold off new words while busy or while a table rebuild is pending
  assign in_stall  = !eng_idle || reinit;
  assign in_fire   = in_valid && !in_stall;
  assign res_ready = !out_valid || !out_stall;

  fbfa_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fbfa_engine #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .reinit      (reinit),
    .fit_policy  (fit_policy),
    .total_space (total_space),
    .in_fire     (in_fire),
    .func        (func),
    .request_id  (request_id),
    .req_size    (req_size),
    .idle        (eng_idle),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  // output register, decouples the result from the next word's walk
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      granted       <= res.granted;
      alloc_address <= res.alloc_address;
      total_free    <= res.total_free;
      largest_free  <= res.largest_free;
    end
  end

endmodule
